/* rtl/core/repeat_offender_table_defines.svh */
// assertion helpers used by the table sequencer
`ifndef REPEAT_OFFENDER_TABLE_DEFINES_SVH
`define REPEAT_OFFENDER_TABLE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ROT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define ROT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/rot_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rot_pkg;

   localparam int DEF_TABLE_DEPTH = 64;

   localparam logic [7:0] COUNT_MAX   = 8'd255;
   localparam logic [6:0] REMOVED_MAX = 7'd127;
   localparam logic [3:0] DIGIT_MAX   = 4'd9;

   localparam logic       CMD_OFFENSE = 1'b0;
   localparam logic       CMD_SWEEP   = 1'b1;

   localparam logic [1:0] REG_MIN_PRIORITY = 2'd0;
   localparam logic [1:0] REG_BLOCK_COUNT  = 2'd1;
   localparam logic [1:0] REG_MAX_AGE      = 2'd2;
   localparam logic [1:0] REG_NO_TIMESTAMP = 2'd3;

   localparam logic [3:0]  RST_MIN_PRIORITY = 4'd1;
   localparam logic [7:0]  RST_BLOCK_COUNT  = 8'd0;
   localparam logic [31:0] RST_MAX_AGE      = 32'd3600;
   localparam logic        RST_NO_TIMESTAMP = 1'b0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } rot_state_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] address;
      logic [7:0]  count;
      logic [31:0] stamp;
   } rot_entry_type;

   typedef struct packed {
      logic        cmd;
      logic [31:0] address;
      logic        has_priority;
      logic [3:0]  alert_priority;
      logic [31:0] now;
   } rot_item_type;

   typedef struct packed {
      logic [3:0]  min_priority;
      logic [7:0]  block_count;
      logic [31:0] max_age;
      logic        no_timestamp;
   } rot_cfg_type;

   typedef struct packed {
      logic       match;
      logic       expired;
      logic [7:0] next_count;
   } rot_eval_type;

   typedef struct packed {
      logic       filtered;
      logic [7:0] hit_count;
      logic       block;
      logic       table_full;
      logic [6:0] removed;
   } rot_result_type;

endpackage

`default_nettype wire

/* rtl/core/rot_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module rot_table
   import rot_pkg::*;
#(
   parameter int DEPTH = DEF_TABLE_DEPTH,
   parameter int IDX_W = $clog2(DEF_TABLE_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output rot_entry_type         rd_data_ff,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire rot_entry_type    wr_data
);

   rot_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/rot_eval.sv */
`timescale 1ns / 1ps
`default_nettype none

module rot_eval
   import rot_pkg::*;
(
   input  wire rot_entry_type entry,
   input  wire logic [31:0]   address,
   input  wire logic [31:0]   now,
   input  wire logic [31:0]   max_age,
   output rot_eval_type       result
);

   logic [32:0] deadline;

   // stamp plus age kept at 33 bits so it cannot wrap
   assign deadline = {1'b0, entry.stamp} + {1'b0, max_age};

   assign result.match      = entry.valid && (entry.address == address);
   assign result.expired    = entry.valid && (deadline < {1'b0, now});
   assign result.next_count = (entry.count == COUNT_MAX) ? COUNT_MAX
                                                         : entry.count + 8'd1;

endmodule

`default_nettype wire

/* rtl/core/rot_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "repeat_offender_table_defines.svh"

module rot_seq
   import rot_pkg::*;
#(
   parameter int DEPTH = DEF_TABLE_DEPTH,
   parameter int IDX_W = $clog2(DEF_TABLE_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rot_cfg_type      cfg,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire rot_item_type     req_item,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output rot_result_type        rsp_result,
   output logic                  rd_en,
   output logic [IDX_W-1:0]      rd_addr,
   input  wire rot_entry_type    rd_data,
   output logic                  wr_en,
   output logic [IDX_W-1:0]      wr_addr,
   output rot_entry_type         wr_data
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   rot_state_type    state_ff, state_in;
   rot_item_type     item_ff, item_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rd_busy_ff, rd_busy_in;
   logic             ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [6:0]       removed_ff, removed_in;
   rot_result_type   result_ff, result_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rot_result_type   rsp_data_ff, rsp_data_in;

   rot_eval_type     ev;
   logic             req_filtered;
   logic             is_offense;
   logic             ev_last;
   logic             out_free;
   logic [6:0]       removed_sat;

   rot_eval u_eval (
      .entry   (rd_data),
      .address (item_ff.address),
      .now     (item_ff.now),
      .max_age (cfg.max_age),
      .result  (ev)
   );

   assign req_filtered = !req_item.has_priority || (req_item.alert_priority > DIGIT_MAX) ||
                         (req_item.alert_priority < cfg.min_priority);
   assign is_offense   = (item_ff.cmd == CMD_OFFENSE);
   assign ev_last      = (ev_idx_ff == LAST_IDX);
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign removed_sat  = (removed_ff == REMOVED_MAX) ? removed_ff : removed_ff + 7'd1;

   assign rd_en      = (state_ff == ST_SCAN) && rd_busy_ff;
   assign rd_addr    = idx_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == LAST_IDX) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_item.cmd == CMD_OFFENSE && req_filtered) state_in = ST_DONE;
               else state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ev_valid_ff && ((is_offense && ev.match) || ev_last)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      item_in       = item_ff;
      idx_in        = idx_ff;
      rd_busy_in    = rd_busy_ff;
      ev_valid_in   = rd_en;
      ev_idx_in     = idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      removed_in    = removed_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = ev_idx_ff;
      wr_data       = rd_data;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '0;
            idx_in  = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               item_in            = req_item;
               idx_in             = '0;
               rd_busy_in         = 1'b1;
               free_found_in      = 1'b0;
               removed_in         = '0;
               result_in          = '0;
               result_in.filtered = (req_item.cmd == CMD_OFFENSE) && req_filtered;
            end
         end
         ST_SCAN: begin
            // reads run one entry ahead of the compare
            if (rd_en) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) rd_busy_in = 1'b0;
            end
            if (ev_valid_ff) begin
               if (is_offense) begin
                  if (ev.match) begin
                     wr_en               = 1'b1;
                     wr_data.count       = ev.next_count;
                     result_in.hit_count = ev.next_count;
                     result_in.block     = (ev.next_count == cfg.block_count);
                     rd_busy_in          = 1'b0;
                  end else begin
                     if (!rd_data.valid && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = ev_idx_ff;
                     end
                     if (ev_last) begin
                        if (free_found_ff || !rd_data.valid) begin
                           wr_en           = 1'b1;
                           wr_addr         = free_found_ff ? free_idx_ff : ev_idx_ff;
                           wr_data.valid   = 1'b1;
                           wr_data.address = item_ff.address;
                           wr_data.count   = '0;
                           wr_data.stamp   = cfg.no_timestamp ? '0 : item_ff.now;
                           result_in.block = (cfg.block_count == '0);
                        end else begin
                           result_in.table_full = 1'b1;
                        end
                     end
                  end
               end else begin
                  if (ev.expired) begin
                     wr_en         = 1'b1;
                     wr_data.valid = 1'b0;
                     removed_in    = removed_sat;
                  end
                  if (ev_last) result_in.removed = ev.expired ? removed_sat : removed_ff;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rd_busy_ff   <= 1'b0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rd_busy_ff   <= rd_busy_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      ev_idx_ff     <= ev_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      removed_ff    <= removed_in;
      result_ff     <= result_in;
      rsp_data_ff   <= rsp_data_in;
   end

   `ROT_ASSERT_IMPL(a_write_when_busy, wr_en, (state_ff == ST_SCAN || state_ff == ST_CLEAR), "table written outside scan or clear")
   `ROT_ASSERT_NEXT(a_accept_leaves_idle, (req_tvalid && req_tready), (state_ff == ST_SCAN || state_ff == ST_DONE), "accepted beat did not start work")
   `ROT_ASSERT_IMPL(a_no_read_when_done, (state_ff == ST_DONE || state_ff == ST_IDLE), !rd_en, "table read while not scanning")

endmodule

`default_nettype wire

/* rtl/core/repeat_offender_table.sv */
// Repeat-offender table: holds up to TABLE_DEPTH offender addresses with hit counts
// and insertion stamps in a single-port-write, single-port-read memory. One compare
// unit is walked over the table, one entry per cycle, so a miss or an aging sweep
// presents its result only once every entry has been read and compared, while a hit
// ends the walk at the matching slot and a filtered offense skips it. req_tready is
// high only between items. After reset a clearing pass empties the table and no beat
// is taken meanwhile; csr writes are taken at any time but should only be made while
// idle. The result sits in an output register, so the next item is taken while it
// waits; a finished item holds until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module repeat_offender_table
   import rot_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // address[31:0], has_priority[32], alert_priority[36:33], now[68:37], zero pad
   input  wire logic [71:0] req_tdata,
   // cmd[0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // filtered[0], hit_count[8:1], block[9], table_full[10], removed[17:11], zero pad
   output logic [23:0]      rsp_tdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   rot_cfg_type      cfg_ff;
   rot_item_type     req_item;
   rot_result_type   rsp_result;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   rot_entry_type    rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   rot_entry_type    wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_priority <= RST_MIN_PRIORITY;
         cfg_ff.block_count  <= RST_BLOCK_COUNT;
         cfg_ff.max_age      <= RST_MAX_AGE;
         cfg_ff.no_timestamp <= RST_NO_TIMESTAMP;
      end else if (csr_we) begin
         case (csr_index)
            REG_MIN_PRIORITY: cfg_ff.min_priority <= csr_wdata[3:0];
            REG_BLOCK_COUNT:  cfg_ff.block_count  <= csr_wdata[7:0];
            REG_MAX_AGE:      cfg_ff.max_age      <= csr_wdata;
            REG_NO_TIMESTAMP: cfg_ff.no_timestamp <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_item.cmd            = req_tuser;
   assign req_item.address        = req_tdata[31:0];
   assign req_item.has_priority   = req_tdata[32];
   assign req_item.alert_priority = req_tdata[36:33];
   assign req_item.now            = req_tdata[68:37];

   assign rsp_tdata = {6'd0, rsp_result.removed, rsp_result.table_full, rsp_result.block,
                       rsp_result.hit_count, rsp_result.filtered};

   rot_table #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock      (clock),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   rot_seq #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

endmodule

`default_nettype wire
